// ===== design/esc_pkg.sv =====
// Package for the epoch-seconds to calendar converter: microcode, tables and encoders.
package esc_pkg;

  localparam logic [31:0] END_OF_RANGE  = 32'd4102444800;
  localparam logic [11:0] FIRST_YEAR    = 12'd1970;
  localparam logic [11:0] LAST_YEAR     = 12'd2099;
  localparam logic [11:0] CENTURY_2000  = 12'd2000;
  localparam logic [11:0] CENTURY_1900  = 12'd1900;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;
  localparam int unsigned PC_W          = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MUL,
    OP_REM,
    OP_FIX,
    OP_DAYS,
    OP_WDAY,
    OP_HOUR,
    OP_MINSEC,
    OP_YEAR,
    OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    OP2_NONE,
    OP2_MONTH
  } op2_e;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_WEEK,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_OOR,
    JMP_SUB
  } jmp_e;

  typedef struct packed {
    op_e        op;
    op2_e       op2;
    dsel_e      dsel;
    jmp_e       jcond;
    pc_t        target;
  } ctrl_t;

  localparam pc_t PC_FIN = pc_t'(19);

  function automatic ctrl_t esc_rom(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_FIN, op2: OP2_NONE, dsel: DSEL_DAY, jcond: JMP_NONE, target: PC_FIN};
    unique case (pc)
      pc_t'(0):  w = '{OP_LOAD,   OP2_NONE,  DSEL_DAY,  JMP_OOR,  PC_FIN};
      pc_t'(1):  w = '{OP_MUL,    OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(2):  w = '{OP_REM,    OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(3):  w = '{OP_FIX,    OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(4):  w = '{OP_DAYS,   OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(5):  w = '{OP_MUL,    OP2_NONE,  DSEL_WEEK, JMP_NONE, PC_FIN};
      pc_t'(6):  w = '{OP_REM,    OP2_NONE,  DSEL_WEEK, JMP_NONE, PC_FIN};
      pc_t'(7):  w = '{OP_FIX,    OP2_NONE,  DSEL_WEEK, JMP_NONE, PC_FIN};
      pc_t'(8):  w = '{OP_WDAY,   OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(9):  w = '{OP_MUL,    OP2_NONE,  DSEL_HOUR, JMP_NONE, PC_FIN};
      pc_t'(10): w = '{OP_REM,    OP2_NONE,  DSEL_HOUR, JMP_NONE, PC_FIN};
      pc_t'(11): w = '{OP_FIX,    OP2_NONE,  DSEL_HOUR, JMP_NONE, PC_FIN};
      pc_t'(12): w = '{OP_HOUR,   OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(13): w = '{OP_MUL,    OP2_NONE,  DSEL_MIN,  JMP_NONE, PC_FIN};
      pc_t'(14): w = '{OP_REM,    OP2_NONE,  DSEL_MIN,  JMP_NONE, PC_FIN};
      pc_t'(15): w = '{OP_FIX,    OP2_NONE,  DSEL_MIN,  JMP_NONE, PC_FIN};
      pc_t'(16): w = '{OP_MINSEC, OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
      pc_t'(17): w = '{OP_YEAR,   OP2_NONE,  DSEL_DAY,  JMP_SUB,  pc_t'(17)};
      pc_t'(18): w = '{OP_YEAR,   OP2_MONTH, DSEL_DAY,  JMP_SUB,  pc_t'(18)};
      default:   w = '{OP_FIN,    OP2_NONE,  DSEL_DAY,  JMP_NONE, PC_FIN};
    endcase
    return w;
  endfunction

  function automatic logic [16:0] esc_divisor(input dsel_e sel);
    logic [16:0] d;
    d = 17'd86400;
    unique case (sel)
      DSEL_DAY:  d = 17'd86400;
      DSEL_WEEK: d = 17'd7;
      DSEL_HOUR: d = 17'd3600;
      DSEL_MIN:  d = 17'd60;
      default:   d = 17'd86400;
    endcase
    return d;
  endfunction

  // floor of 2**42 over the divisor for a day, floor of 2**17 over it otherwise
  function automatic logic [25:0] esc_magic(input dsel_e sel);
    logic [25:0] m;
    m = 26'd50903316;
    unique case (sel)
      DSEL_DAY:  m = 26'd50903316;
      DSEL_WEEK: m = 26'd18724;
      DSEL_HOUR: m = 26'd36;
      DSEL_MIN:  m = 26'd2184;
      default:   m = 26'd50903316;
    endcase
    return m;
  endfunction

  function automatic logic [8:0] esc_month_len(input logic [3:0] month, input logic leap);
    logic [8:0] n;
    n = 9'd31;
    case (month)
      4'd2:                     n = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 9'd30;
      default:                  n = 9'd31;
    endcase
    return n;
  endfunction

  // two BCD digits of a value below 100
  function automatic logic [7:0] esc_bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== design/epoch_seconds_to_calendar_top.sv =====
// Epoch-seconds to calendar converter: microcoded sequencer and shared divide datapath.
//
// Input stream: s_axis_tdata carries a 32-bit count of seconds since 1970-01-01 00:00:00.
// Output stream: m_axis_tdata carries year, month, day, hour, minute, second and weekday;
// m_axis_tuser is the out-of-range flag (count past end of 2099, all fields then zero).
// cfg_we_i/cfg_wdata_i write the mode bit: 0 binary fields, 1 packed BCD fields
// (weekday stays binary). Write it only while no conversion is in flight.
// One item is converted at a time. A short program in a control ROM steps a single
// reciprocal-multiply unit: each division by a constant (seconds of a day, seven,
// seconds of an hour, sixty) takes a multiply, a remainder and a correction step.
// Then the year loop takes one step per elapsed year plus one (up to 130) and the
// month loop one step per elapsed month plus one (up to 12).
// The time from transfer in to result valid varies with the year and month loops;
// an out-of-range count jumps from the first step straight to the final one.
// The result sits in an output register; the next item is taken as soon as the
// sequencer is free, and a stalled receiver only holds the final step of the next item.
// Reset clears the sequencer, the output valid and the mode bit (binary).
module epoch_seconds_to_calendar_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] year_out, [18:14] month_out, [24:19] day_out, [30:25] hour_out,
  // [37:31] minute_out, [44:38] second_out, [47:45] weekday_out
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] out_of_range
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import esc_pkg::*;

  logic        busy_q, busy_d;
  pc_t         pc_q, pc_d;
  logic        bcd_q;
  logic        oval_q, oval_d;
  logic [31:0] secs_q;
  logic [31:0] acc_q, acc_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] days_q, days_d;
  logic [16:0] tod_q, tod_d;
  logic [2:0]  wday_q, wday_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic        oor_q, oor_d;
  logic [47:0] odata_q, odata_d;
  logic        ouser_q, ouser_d;

  ctrl_t       ctrl;
  logic        start;
  logic        fin_go;
  logic [31:0] divisor;
  logic [57:0] mul_prod;
  logic [15:0] quo_est;
  logic [31:0] quo_mul;
  logic        ge;
  logic        leap;
  logic [8:0]  step_len;
  logic        can_sub;
  logic        take;
  logic [13:0] year_enc;
  logic [4:0]  month_enc;
  logic [5:0]  day_enc;
  logic [5:0]  hour_enc;
  logic [6:0]  min_enc;
  logic [6:0]  sec_enc;
  logic [6:0]  day_val;
  logic [6:0]  year_lo;
  logic [7:0]  year_hi;

  assign ctrl          = esc_rom(pc_q);
  assign s_axis_tready = !busy_q;
  assign start         = s_axis_tvalid && !busy_q;
  assign fin_go        = busy_q && (ctrl.op == OP_FIN) && (!oval_q || m_axis_tready);
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // shared divide unit: estimate by reciprocal, then remainder and one correction
  assign divisor  = 32'(esc_divisor(ctrl.dsel));
  assign mul_prod = 58'(acc_q) * 58'(esc_magic(ctrl.dsel));
  assign quo_est  = (ctrl.dsel == DSEL_DAY) ? mul_prod[57:42] : mul_prod[32:17];
  assign quo_mul  = 32'(quo_q) * divisor;
  assign ge       = acc_q >= divisor;

  // only 2000 is a century year in range, and it is a leap year
  assign leap     = (year_q[1:0] == 2'b00);
  assign step_len = (ctrl.op2 == OP2_MONTH) ? esc_month_len(month_q, leap)
                                            : (leap ? 9'd366 : 9'd365);
  assign can_sub  = (ctrl.op2 == OP2_MONTH) ? (month_q != LAST_MONTH) && (days_q >= 16'(step_len))
                                            : (year_q != LAST_YEAR) && (days_q >= 16'(step_len));

  always_comb begin
    take = 1'b0;
    unique case (ctrl.jcond)
      JMP_NONE:   take = 1'b0;
      JMP_OOR:    take = (secs_q >= END_OF_RANGE);
      JMP_SUB:    take = can_sub;
      default:    take = 1'b0;
    endcase
  end

  // control path
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    oval_d = oval_q;
    if (oval_q && m_axis_tready) begin
      oval_d = 1'b0;
    end
    if (start) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q) begin
      if (ctrl.op == OP_FIN) begin
        if (fin_go) begin
          busy_d = 1'b0;
          oval_d = 1'b1;
        end
      end else begin
        pc_d = take ? ctrl.target : pc_q + pc_t'(1);
      end
    end
  end

  // output encoding
  assign day_val = 7'(days_q) + 7'd1;
  assign year_lo = (year_q >= CENTURY_2000) ? 7'(year_q - CENTURY_2000)
                                            : 7'(year_q - CENTURY_1900);
  assign year_hi = (year_q >= CENTURY_2000) ? 8'h20 : 8'h19;

  always_comb begin
    if (bcd_q) begin
      year_enc  = 14'({year_hi, esc_bcd2(year_lo)});
      month_enc = 5'(esc_bcd2(7'(month_q)));
      day_enc   = 6'(esc_bcd2(day_val));
      hour_enc  = 6'(esc_bcd2(7'(hour_q)));
      min_enc   = 7'(esc_bcd2(7'(min_q)));
      sec_enc   = 7'(esc_bcd2(7'(sec_q)));
    end else begin
      year_enc  = 14'(year_q);
      month_enc = 5'(month_q);
      day_enc   = 6'(day_val);
      hour_enc  = 6'(hour_q);
      min_enc   = 7'(min_q);
      sec_enc   = 7'(sec_q);
    end
  end

  // datapath
  always_comb begin
    acc_d   = acc_q;
    quo_d   = quo_q;
    days_d  = days_q;
    tod_d   = tod_q;
    wday_d  = wday_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    year_d  = year_q;
    month_d = month_q;
    oor_d   = oor_q;
    odata_d = odata_q;
    ouser_d = ouser_q;
    if (start) begin
      // hold nothing: secs_q is loaded in the clocked block
    end else if (busy_q) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          acc_d = secs_q;
          oor_d = (secs_q >= END_OF_RANGE);
        end
        OP_MUL: begin
          quo_d = quo_est;
        end
        OP_REM: begin
          acc_d = acc_q - quo_mul;
        end
        OP_FIX: begin
          if (ge) begin
            acc_d = acc_q - divisor;
            quo_d = quo_q + 16'd1;
          end
        end
        OP_DAYS: begin
          days_d = quo_q;
          tod_d  = acc_q[16:0];
          acc_d  = 32'(quo_q + EPOCH_WEEKDAY);
        end
        OP_WDAY: begin
          wday_d = acc_q[2:0];
          acc_d  = 32'(tod_q);
        end
        OP_HOUR: begin
          hour_d = quo_q[4:0];
        end
        OP_MINSEC: begin
          min_d   = quo_q[5:0];
          sec_d   = acc_q[5:0];
          year_d  = FIRST_YEAR;
          month_d = 4'd1;
        end
        OP_YEAR: begin
          if (can_sub) begin
            days_d = days_q - 16'(step_len);
            if (ctrl.op2 == OP2_MONTH) begin
              month_d = month_q + 4'd1;
            end else begin
              year_d = year_q + 12'd1;
            end
          end
        end
        OP_FIN: begin
          if (fin_go) begin
            ouser_d = oor_q;
            if (oor_q) begin
              odata_d = '0;
            end else begin
              odata_d = {wday_q, sec_enc, min_enc, hour_enc, day_enc, month_enc, year_enc};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      oval_q <= 1'b0;
      bcd_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      oval_q <= oval_d;
      if (cfg_we_i) begin
        bcd_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      secs_q <= s_axis_tdata;
    end
    acc_q   <= acc_d;
    quo_q   <= quo_d;
    days_q  <= days_d;
    tod_q   <= tod_d;
    wday_q  <= wday_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    year_q  <= year_d;
    month_q <= month_d;
    oor_q   <= oor_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

endmodule

// ===== tb/epoch_seconds_to_calendar_top_tb.sv =====
// Self-checking testbench for the epoch-seconds to calendar converter: predicted dates vs. stream.
module epoch_seconds_to_calendar_top_tb;

  localparam bit MODE_BINARY = 1'b0;
  localparam bit MODE_BCD    = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SECS_IN_DAY = 86400;
  localparam int unsigned MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam logic [31:0] EDGE_COUNTS[17] = '{
    32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400, 32'd63071999,
    32'd68169600, 32'd946684800, 32'd951782400, 32'd951868799, 32'd1000000000,
    32'd2147483648, 32'd4102444799, 32'd4102444800, 32'hFFFFFFFF};

  typedef struct packed {
    logic [13:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [2:0]  weekday;
    logic        oor;
  } date_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;

  bit          bcd_mode = MODE_BINARY;
  bit          gaps_on  = 1'b1;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  date_t       pending_dates[$];

  epoch_seconds_to_calendar_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
    return MONTH_DAYS[mo - 1] + ((mo == 2 && leap_year(yr)) ? 1 : 0);
  endfunction

  function automatic logic [15:0] encode_field(input int unsigned v, input bit bcd);
    logic [15:0] digits;
    digits = '0;
    if (!bcd) begin
      return 16'(v);
    end
    for (int k = 0; k < 4; k++) begin
      digits[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return digits;
  endfunction

  function automatic date_t predict_calendar(input logic [31:0] secs, input bit bcd);
    date_t       d;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    d = '0;
    if (secs >= esc_pkg::END_OF_RANGE) begin
      d.oor = 1'b1;
      return d;
    end
    days = secs / SECS_IN_DAY;
    rem  = secs % SECS_IN_DAY;
    d.weekday = 3'((days + 4) % 7);
    yr = 1970;
    while (yr < 2099) begin
      len = leap_year(yr) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    mo = 1;
    while (mo < 12) begin
      len = days_in_month(mo, yr);
      if (days < len) break;
      days -= len;
      mo++;
    end
    d.year   = 14'(encode_field(yr, bcd));
    d.month  = 5'(encode_field(mo, bcd));
    d.day    = 6'(encode_field(days + 1, bcd));
    d.hour   = 6'(encode_field(rem / 3600, bcd));
    d.minute = 7'(encode_field((rem % 3600) / 60, bcd));
    d.second = 7'(encode_field(rem % 60, bcd));
    return d;
  endfunction

  function automatic logic [31:0] pick_seconds();
    int unsigned roll;
    int unsigned yr;
    int unsigned mo;
    int unsigned days;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(0, 32'd4102444799);
    end else if (roll < 80) begin
      yr   = $urandom_range(1971, 2099);
      mo   = $urandom_range(1, 12);
      days = 0;
      for (int unsigned y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
      for (int unsigned m = 1; m < mo; m++) days += days_in_month(m, yr);
      return days * SECS_IN_DAY - $urandom_range(0, 1);
    end else if (roll < 88) begin
      return $urandom_range(0, 47481) * SECS_IN_DAY + $urandom_range(0, 1) * 86399;
    end else if (roll < 93) begin
      return esc_pkg::END_OF_RANGE - 32'd100 + $urandom_range(0, 199);
    end
    return $urandom_range(esc_pkg::END_OF_RANGE, 32'hFFFFFFFF);
  endfunction

  task automatic send_seconds(input logic [31:0] secs);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = secs;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(predict_calendar(secs, bcd_mode));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    wait_for_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    bcd_mode    = mode;
  endtask

  task automatic test_edge_counts(input bit mode);
    write_mode(mode);
    foreach (EDGE_COUNTS[i]) send_seconds(EDGE_COUNTS[i]);
    wait_for_results();
  endtask

  task automatic test_random_counts(input bit mode, input int unsigned count);
    write_mode(mode);
    repeat (count) send_seconds(pick_seconds());
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_counts(MODE_BCD, 150);
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_for_results();
    write_mode(MODE_BINARY);
    repeat (12) begin
      repeat ($urandom_range(1, 3)) send_seconds(pick_seconds());
      wait_for_results();
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = !(gaps_on && $urandom_range(0, 99) < 25);
  end

  always @(posedge clk_i) begin
    date_t want;
    date_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[13:0], m_axis_tdata[18:14], m_axis_tdata[24:19],
             m_axis_tdata[30:25], m_axis_tdata[37:31], m_axis_tdata[44:38],
             m_axis_tdata[47:45], m_axis_tuser};
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected transfer expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.year, got.year);
        check_field("month", want.month, got.month);
        check_field("day", want.day, got.day);
        check_field("hour", want.hour, got.hour);
        check_field("minute", want.minute, got.minute);
        check_field("second", want.second, got.second);
        check_field("weekday", want.weekday, got.weekday);
        check_field("out_of_range", want.oor, got.oor);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_edge_counts(MODE_BINARY);
    test_edge_counts(MODE_BCD);
    test_random_counts(MODE_BCD, 230);
    test_random_counts(MODE_BINARY, 230);
    test_back_to_back();
    test_pause_for_results();
    wait_for_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
